### rtl/core/qrs_pkg.sv
// qrs_pkg: widths, codes, item types and helper functions for the quadratic root solver.
// Used by every module under rtl/core; depends on nothing.
package qrs_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;

    // Derived widths
    localparam int PROD_W = 2 * WORD_BITS;          // b*b, a*c magnitudes
    localparam int DMAG_W = 2 * WORD_BITS + 2;      // |b*b - 4ac|
    localparam int SQ_W   = DMAG_W / 2;             // isqrt result
    localparam int MP_W   = SQ_W + 1;               // |b| + isqrt
    localparam int NUM_W  = MP_W + FRAC_BITS;       // dividend / quotient
    localparam int DEN_W  = MP_W;                   // divisor

    localparam int IN_TDATA_W  = ((3 * WORD_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((2 * WORD_BITS + 7) / 8) * 8;
    localparam int OUT_TUSER_W = 3;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    typedef enum logic [1:0] {
        ST_INVALID = 2'd0,
        ST_COMPLEX = 2'd1,
        ST_REAL    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        D_NEG  = 2'd0,
        D_ZERO = 2'd1,
        D_POS  = 2'd2
    } t_dsign;

    typedef logic [WORD_BITS-1:0] t_word;

    typedef struct packed {
        logic   a_zero;
        logic   na;
        logic   nb;
        logic   nc;
        t_word  ma;
        t_word  mb;
        t_word  mc;
        t_dsign dsign;
    } t_tag;

    typedef struct packed {
        t_tag              tag;
        logic [DMAG_W-1:0] dmag;
    } t_item;

    typedef struct packed {
        logic   a_zero;
        t_dsign dsign;
        logic   neg0;
        logic   neg1;
    } t_dtag;

    // queue status seen by the front and back ends
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic t_word mag_of(input t_word v);
        t_word r;
        r = v[WORD_BITS-1] ? (~v + t_word'(1)) : v;
        return r;
    endfunction

    // returns {sat, word}
    function automatic logic [WORD_BITS:0] clamp_word(input logic neg,
                                                       input logic [NUM_W-1:0] q);
        logic [NUM_W-1:0] lim;
        logic [NUM_W-1:0] v;
        logic             sat;
        t_word            w;
        lim = NUM_W'(1) << (WORD_BITS - 1);
        if (!neg) lim = lim - NUM_W'(1);
        sat = (q > lim);
        v   = sat ? lim : q;
        w   = neg ? (t_word'(0) - v[WORD_BITS-1:0]) : v[WORD_BITS-1:0];
        return {sat, w};
    endfunction

endpackage

### rtl/core/qrs_front.sv
// qrs_front: accepts coefficient items, forms magnitudes, products and the discriminant.
// Depends on qrs_pkg.
module qrs_front import qrs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_word                i_coef_a,
    input  t_word                i_coef_b,
    input  t_word                i_coef_c,
    input  t_qstat               i_qstat,
    output logic                 o_push,
    output t_item                o_item
);

    logic              adv;
    logic [2:0]        r_vld;
    t_tag              r_tag0, r_tag1;
    logic [PROD_W-1:0] r_b2, r_ac;
    t_item             r_item;
    t_item             n_item;
    logic [DMAG_W-1:0] b2, ac4;

    assign adv     = !r_vld[2] || !i_qstat.full;
    assign o_ready = adv;
    assign o_push  = r_vld[2] && !i_qstat.full;
    assign o_item  = r_item;

    always_comb begin
        b2  = DMAG_W'(r_b2);
        ac4 = {r_ac, 2'b00};
        n_item     = '0;
        n_item.tag = r_tag1;
        if (r_tag1.mc != '0 && r_tag1.na != r_tag1.nc) begin
            n_item.tag.dsign = D_POS;
            n_item.dmag      = b2 + ac4;
        end else if (b2 > ac4) begin
            n_item.tag.dsign = D_POS;
            n_item.dmag      = b2 - ac4;
        end else if (b2 == ac4) begin
            n_item.tag.dsign = D_ZERO;
            n_item.dmag      = '0;
        end else begin
            n_item.tag.dsign = D_NEG;
            n_item.dmag      = ac4 - b2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_tag0.na     <= i_coef_a[WORD_BITS-1];
            r_tag0.nb     <= i_coef_b[WORD_BITS-1];
            r_tag0.nc     <= i_coef_c[WORD_BITS-1];
            r_tag0.ma     <= mag_of(i_coef_a);
            r_tag0.mb     <= mag_of(i_coef_b);
            r_tag0.mc     <= mag_of(i_coef_c);
            r_tag0.a_zero <= (i_coef_a == '0);
            r_tag0.dsign  <= D_ZERO;
            r_tag1        <= r_tag0;
            r_b2          <= PROD_W'(r_tag0.mb) * PROD_W'(r_tag0.mb);
            r_ac          <= PROD_W'(r_tag0.ma) * PROD_W'(r_tag0.mc);
            r_item        <= n_item;
        end
    end

endmodule

### rtl/core/qrs_queue.sv
// qrs_queue: short register queue that decouples the front end from the back end.
// Depends on qrs_pkg.
module qrs_queue import qrs_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_item  i_item,
    input  logic   i_pop,
    output t_qstat o_qstat,
    output t_item  o_item
);

    t_item             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr, r_rptr;
    logic [QPTR_W:0]   r_cnt;

    assign o_qstat.full  = (r_cnt == (QPTR_W+1)'(QDEPTH));
    assign o_qstat.empty = (r_cnt == '0);
    assign o_item        = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) r_wptr <= r_wptr + QPTR_W'(1);
            if (i_pop)  r_rptr <= r_rptr + QPTR_W'(1);
            r_cnt <= r_cnt + (QPTR_W+1)'(i_push) - (QPTR_W+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_item;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QPTR_W+1)'(QDEPTH))
        else $error("queue count above depth");

    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |=> r_cnt == $past(r_cnt) + (QPTR_W+1)'(1))
        else $error("queue count missed a push");

endmodule

### rtl/core/qrs_div.sv
// qrs_div: two-lane pipelined restoring divider, one quotient bit per stage.
// Depends on qrs_pkg.
module qrs_div import qrs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_valid,
    input  t_dtag            i_tag,
    input  logic [NUM_W-1:0] i_num0,
    input  logic [DEN_W-1:0] i_den0,
    input  logic [NUM_W-1:0] i_num1,
    input  logic [DEN_W-1:0] i_den1,
    output logic             o_valid,
    output t_dtag            o_tag,
    output logic [NUM_W-1:0] o_q0,
    output logic [NUM_W-1:0] o_q1
);

    logic [NUM_W-1:0] s_num [0:NUM_W][2];
    logic [NUM_W-1:0] s_q   [0:NUM_W][2];
    logic [DEN_W-1:0] s_rem [0:NUM_W][2];
    logic [DEN_W-1:0] s_den [0:NUM_W][2];

    logic [NUM_W-1:0] r_num [1:NUM_W][2];
    logic [NUM_W-1:0] r_q   [1:NUM_W][2];
    logic [DEN_W-1:0] r_rem [1:NUM_W][2];
    logic [DEN_W-1:0] r_den [1:NUM_W][2];
    t_dtag            r_tag [1:NUM_W];
    logic [NUM_W:1]   r_vld;

    logic [NUM_W-1:0] n_num [1:NUM_W][2];
    logic [NUM_W-1:0] n_q   [1:NUM_W][2];
    logic [DEN_W-1:0] n_rem [1:NUM_W][2];

    always_comb begin
        logic [DEN_W:0] t;
        s_num[0][0] = i_num0;  s_num[0][1] = i_num1;
        s_den[0][0] = i_den0;  s_den[0][1] = i_den1;
        s_q[0][0]   = '0;      s_q[0][1]   = '0;
        s_rem[0][0] = '0;      s_rem[0][1] = '0;
        for (int k = 1; k <= NUM_W; k++) begin
            for (int l = 0; l < 2; l++) begin
                s_num[k][l] = r_num[k][l];
                s_den[k][l] = r_den[k][l];
                s_q[k][l]   = r_q[k][l];
                s_rem[k][l] = r_rem[k][l];
            end
        end
        for (int k = 1; k <= NUM_W; k++) begin
            for (int l = 0; l < 2; l++) begin
                t = {s_rem[k-1][l], s_num[k-1][l][NUM_W-1]};
                n_num[k][l] = s_num[k-1][l] << 1;
                if (t >= {1'b0, s_den[k-1][l]}) begin
                    n_rem[k][l] = DEN_W'(t - {1'b0, s_den[k-1][l]});
                    n_q[k][l]   = {s_q[k-1][l][NUM_W-2:0], 1'b1};
                end else begin
                    n_rem[k][l] = t[DEN_W-1:0];
                    n_q[k][l]   = {s_q[k-1][l][NUM_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[NUM_W-1:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_tag[1] <= i_tag;
            for (int k = 2; k <= NUM_W; k++) r_tag[k] <= r_tag[k-1];
            for (int k = 1; k <= NUM_W; k++) begin
                for (int l = 0; l < 2; l++) begin
                    r_num[k][l] <= n_num[k][l];
                    r_q[k][l]   <= n_q[k][l];
                    r_rem[k][l] <= n_rem[k][l];
                    r_den[k][l] <= s_den[k-1][l];
                end
            end
        end
    end

    assign o_valid = r_vld[NUM_W];
    assign o_tag   = r_tag[NUM_W];
    assign o_q0    = r_q[NUM_W][0];
    assign o_q1    = r_q[NUM_W][1];

endmodule

### rtl/core/qrs_back.sv
// qrs_back: pipelined integer square root, divider set-up, divider and output register.
// Depends on qrs_pkg and qrs_div.
module qrs_back import qrs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_qstat  i_qstat,
    input  t_item   i_item,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_ready,
    output t_status o_status,
    output t_word   o_root_first,
    output t_word   o_root_second,
    output logic    o_sat
);

    logic adv;

    // square root pipeline, two radicand bits per stage
    logic [SQ_W+1:0]   r_sq_rem  [0:SQ_W];
    logic [SQ_W-1:0]   r_sq_root [0:SQ_W];
    logic [DMAG_W-1:0] r_sq_n    [0:SQ_W];
    t_tag              r_sq_tag  [0:SQ_W];
    logic [SQ_W:0]     r_sq_vld;

    logic [SQ_W+1:0]   n_sq_rem  [1:SQ_W];
    logic [SQ_W-1:0]   n_sq_root [1:SQ_W];

    // divider set-up stage
    logic             r_su_vld;
    t_dtag            r_su_tag;
    logic [NUM_W-1:0] r_su_num0, r_su_num1;
    logic [DEN_W-1:0] r_su_den0, r_su_den1;
    t_dtag            n_su_tag;
    logic [NUM_W-1:0] n_su_num0, n_su_num1;
    logic [DEN_W-1:0] n_su_den0, n_su_den1;

    logic             dv_vld;
    t_dtag            dv_tag;
    logic [NUM_W-1:0] dv_q0, dv_q1;

    // output register
    logic    r_out_vld;
    t_status r_status, n_status;
    t_word   r_r1, r_r2, n_r1, n_r2;
    logic    r_sat, n_sat;

    assign adv   = !r_out_vld || i_ready;
    assign o_pop = adv && !i_qstat.empty;

    always_comb begin
        logic [SQ_W+1:0] t, x;
        for (int k = 1; k <= SQ_W; k++) begin
            x = {r_sq_rem[k-1][SQ_W-1:0], r_sq_n[k-1][DMAG_W-1 -: 2]};
            t = {r_sq_root[k-1], 2'b01};
            if (x >= t) begin
                n_sq_rem[k]  = x - t;
                n_sq_root[k] = {r_sq_root[k-1][SQ_W-2:0], 1'b1};
            end else begin
                n_sq_rem[k]  = x;
                n_sq_root[k] = {r_sq_root[k-1][SQ_W-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        logic [SQ_W-1:0]  s;
        logic [MP_W-1:0]  mp;
        logic [DEN_W-1:0] den_a;
        t_tag             tg;
        s     = r_sq_root[SQ_W];
        tg    = r_sq_tag[SQ_W];
        mp    = MP_W'(tg.mb) + MP_W'(s);
        den_a = DEN_W'({tg.ma, 1'b0});
        n_su_tag.a_zero = tg.a_zero;
        n_su_tag.dsign  = tg.dsign;
        if (tg.dsign == D_POS) begin
            // cancellation-free pair: c/q and q/a
            n_su_num0     = NUM_W'(tg.mc) << (FRAC_BITS + 1);
            n_su_den0     = mp;
            n_su_tag.neg0 = (tg.mc != '0) && (tg.nc == tg.nb);
            n_su_num1     = NUM_W'(mp) << FRAC_BITS;
            n_su_den1     = den_a;
            n_su_tag.neg1 = (tg.na == tg.nb);
        end else begin
            n_su_num0     = NUM_W'(tg.mb) << FRAC_BITS;
            n_su_den0     = den_a;
            n_su_tag.neg0 = (tg.mb != '0) && (tg.nb == tg.na);
            n_su_num1     = NUM_W'(s) << FRAC_BITS;
            n_su_den1     = den_a;
            n_su_tag.neg1 = 1'b0;
        end
    end

    qrs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (r_su_vld),
        .i_tag   (r_su_tag),
        .i_num0  (r_su_num0),
        .i_den0  (r_su_den0),
        .i_num1  (r_su_num1),
        .i_den1  (r_su_den1),
        .o_valid (dv_vld),
        .o_tag   (dv_tag),
        .o_q0    (dv_q0),
        .o_q1    (dv_q1)
    );

    always_comb begin
        logic [WORD_BITS:0] c0, c1;
        c0 = clamp_word(dv_tag.neg0, dv_q0);
        c1 = clamp_word(dv_tag.neg1, dv_q1);
        if (dv_tag.a_zero) begin
            n_status = ST_INVALID;
            n_r1     = '0;
            n_r2     = '0;
            n_sat    = 1'b0;
        end else begin
            case (dv_tag.dsign)
                D_POS: begin
                    n_status = ST_REAL;
                    n_r1     = c0[WORD_BITS-1:0];
                    n_r2     = c1[WORD_BITS-1:0];
                    n_sat    = c0[WORD_BITS] | c1[WORD_BITS];
                end
                D_ZERO: begin
                    n_status = ST_REAL;
                    n_r1     = c0[WORD_BITS-1:0];
                    n_r2     = c0[WORD_BITS-1:0];
                    n_sat    = c0[WORD_BITS];
                end
                default: begin
                    n_status = ST_COMPLEX;
                    n_r1     = c0[WORD_BITS-1:0];
                    n_r2     = c1[WORD_BITS-1:0];
                    n_sat    = c0[WORD_BITS] | c1[WORD_BITS];
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld  <= '0;
            r_su_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_sq_vld  <= {r_sq_vld[SQ_W-1:0], o_pop};
            r_su_vld  <= r_sq_vld[SQ_W];
            r_out_vld <= dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
            r_sq_n[0]    <= i_item.dmag;
            r_sq_tag[0]  <= i_item.tag;
            for (int k = 1; k <= SQ_W; k++) begin
                r_sq_rem[k]  <= n_sq_rem[k];
                r_sq_root[k] <= n_sq_root[k];
                r_sq_n[k]    <= r_sq_n[k-1] << 2;
                r_sq_tag[k]  <= r_sq_tag[k-1];
            end
            r_su_tag  <= n_su_tag;
            r_su_num0 <= n_su_num0;
            r_su_num1 <= n_su_num1;
            r_su_den0 <= n_su_den0;
            r_su_den1 <= n_su_den1;
            r_status  <= n_status;
            r_r1      <= n_r1;
            r_r2      <= n_r2;
            r_sat     <= n_sat;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_status      = r_status;
    assign o_root_first  = r_r1;
    assign o_root_second = r_r2;
    assign o_sat         = r_sat;

endmodule

### rtl/core/quadratic_root_solver.sv
// quadratic_root_solver: roots of a*x^2 + b*x + c in signed Q16.16, one item in, one item out.
// Stages: 3 front + 1 queue + 1 + 33 square-root + 1 set-up + 50 divider stages; one output reg.
// Throughput: one item per cycle while the sink is ready;
//   the root and divider pipelines are fully staged.
// Reset (i_rst_n low, synchronous) empties every pipeline stage and the queue; no other state.
// Depends on qrs_pkg, qrs_front, qrs_queue, qrs_back (which holds qrs_div).
module quadratic_root_solver import qrs_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // coef_a, coef_b, coef_c (low to high)
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // root_first, root_second (low to high)
    output logic [OUT_TUSER_W-1:0] o_m_tuser    // status[1:0], saturated
);

    // front end -> queue
    logic   f_push;
    t_item  f_item;
    t_qstat q_stat;
    logic   q_full;

    // queue -> back end
    t_item  q_item;
    logic   b_pop;

    t_status b_status;
    t_word   b_r1, b_r2;
    logic    b_sat;

    assign q_full = q_stat.full;

    // Front: split signs/magnitudes, b*b and a*c, then the exact discriminant.
    qrs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_coef_a (i_s_tdata[WORD_BITS-1:0]),
        .i_coef_b (i_s_tdata[2*WORD_BITS-1:WORD_BITS]),
        .i_coef_c (i_s_tdata[3*WORD_BITS-1:2*WORD_BITS]),
        .i_qstat  (q_stat),
        .o_push   (f_push),
        .o_item   (f_item)
    );

    // Queue lets the front keep taking items while the back end is held by the sink, until it fills.
    qrs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_item  (f_item),
        .i_pop   (b_pop),
        .o_qstat (q_stat),
        .o_item  (q_item)
    );

    // Back: isqrt, divider set-up, two-lane divider, clamp into the output register.
    qrs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_qstat       (q_stat),
        .i_item        (q_item),
        .o_pop         (b_pop),
        .o_valid       (o_m_tvalid),
        .i_ready       (i_m_tready),
        .o_status      (b_status),
        .o_root_first  (b_r1),
        .o_root_second (b_r2),
        .o_sat         (b_sat)
    );

    assign o_m_tdata = OUT_TDATA_W'({b_r2, b_r1});
    assign o_m_tuser = {b_sat, b_status};

    // a zero coefficient a gives an all-zero result
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser[1:0] == ST_INVALID) |-> (o_m_tdata == '0) && !o_m_tuser[2])
        else $error("invalid status with nonzero roots");

    // imaginary magnitude is never negative
    a_imag_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser[1:0] == ST_COMPLEX) |-> !o_m_tdata[2*WORD_BITS-1])
        else $error("negative imaginary magnitude");

    // input is held off only by a full queue
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> q_full)
        else $error("input stalled with room in the queue");

endmodule
